// ===== rtl/pbls_pkg.sv =====
// pbls_pkg: shared types and constants for the power button / lid sequencer
// used by power_button_lid_sequencer_unit and its port checker; no dependencies
`default_nettype none

package pbls_pkg;

    localparam int DEB_W  = 20;
    localparam int DLY_W  = 24;
    localparam int CIDX_W = 3;
    localparam int CDAT_W = 24;
    localparam int CODE_W = 4;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_BTN_DEBOUNCE = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_LID_DEBOUNCE = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_FIRST_PULSE  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_RELEASE_GAP  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_WAKE_PULSE   = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_BOOT_CAUSE   = 3'd5;

    // configuration reset values
    localparam logic [DEB_W-1:0] RST_BTN_DEBOUNCE = 20'd30000;
    localparam logic [DEB_W-1:0] RST_LID_DEBOUNCE = 20'd30000;
    localparam logic [DLY_W-1:0] RST_FIRST_PULSE  = 24'd32000;
    localparam logic [DLY_W-1:0] RST_RELEASE_GAP  = 24'd3968000;
    localparam logic [DLY_W-1:0] RST_WAKE_PULSE   = 24'd200000;

    // boot causes
    localparam logic [1:0] BOOT_NORMAL       = 2'd0;
    localparam logic [1:0] BOOT_KBD_RESET    = 2'd1;
    localparam logic [1:0] BOOT_KBD_RECOVERY = 2'd2;
    localparam logic [1:0] BOOT_WAKE_PIN     = 2'd3;

    // reported sequencer state codes
    localparam logic [CODE_W-1:0] CODE_IDLE     = 4'd0;
    localparam logic [CODE_W-1:0] CODE_PRESSED  = 4'd1;
    localparam logic [CODE_W-1:0] CODE_T0       = 4'd2;
    localparam logic [CODE_W-1:0] CODE_T1       = 4'd3;
    localparam logic [CODE_W-1:0] CODE_HELD     = 4'd4;
    localparam logic [CODE_W-1:0] CODE_LIDOPEN  = 4'd5;
    localparam logic [CODE_W-1:0] CODE_RELEASED = 4'd6;
    localparam logic [CODE_W-1:0] CODE_EAT      = 4'd7;
    localparam logic [CODE_W-1:0] CODE_RECOVERY = 4'd8;
    localparam logic [CODE_W-1:0] CODE_WASOFF   = 4'd9;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_PRESSED  = 10'b00_0000_0010,
        ST_T0       = 10'b00_0000_0100,
        ST_T1       = 10'b00_0000_1000,
        ST_HELD     = 10'b00_0001_0000,
        ST_LIDOPEN  = 10'b00_0010_0000,
        ST_RELEASED = 10'b00_0100_0000,
        ST_EAT      = 10'b00_1000_0000,
        ST_RECOVERY = 10'b01_0000_0000,
        ST_WASOFF   = 10'b10_0000_0000
    } t_seq_state;

    function automatic logic [CODE_W-1:0] state_code(input t_seq_state s);
        logic [CODE_W-1:0] c;
        case (s)
            ST_IDLE:     c = CODE_IDLE;
            ST_PRESSED:  c = CODE_PRESSED;
            ST_T0:       c = CODE_T0;
            ST_T1:       c = CODE_T1;
            ST_HELD:     c = CODE_HELD;
            ST_LIDOPEN:  c = CODE_LIDOPEN;
            ST_RELEASED: c = CODE_RELEASED;
            ST_EAT:      c = CODE_EAT;
            ST_RECOVERY: c = CODE_RECOVERY;
            ST_WASOFF:   c = CODE_WASOFF;
            default:     c = CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/power_button_lid_sequencer_unit.sv =====
// power_button_lid_sequencer_unit: debounce of button and lid, pulse sequencer to chipset
// depends on pbls_pkg
//
//  channel   | handshake                | payload
//  ----------+--------------------------+---------------------------------------------
//  tick in   | i_valid / o_stall        | raw button, raw lid, chipset off, keys, bl req
//  result    | o_valid / i_stall        | pch level, debounced flags, events, state
//  config    | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// one tick request per clock while o_stall is low; the whole tick is evaluated combinationally from the
// state registers into the result register, so the result shows in the cycle after accept.
// the rate is set by the single state update per tick (debounce counters, delay timer, fsm).
// o_stall is high only while the result register is full and the consumer stalls.
// synchronous active-low reset; config reads its reset values, no clearing pass.
`default_nettype none

module power_button_lid_sequencer_unit
    import pbls_pkg::*;
#(
    parameter int TIMER_BITS = 24
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic                i_raw_button,
    input  wire logic                i_raw_lid,
    input  wire logic                i_chipset_off,
    input  wire logic                i_recovery_keys,
    input  wire logic                i_panel_backlight_request,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic                     o_pch_button_level,
    output logic                     o_button_debounced,
    output logic                     o_lid_debounced,
    output logic                     o_backlight_on,
    output logic                     o_keyboard_scan_on,
    output logic                     o_wake_chipset,
    output logic                     o_event_button,
    output logic                     o_event_lid_open,
    output logic                     o_event_lid_closed,
    output logic [CODE_W-1:0]        o_sequencer_state,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CIDX_W-1:0]   i_cfg_index,
    input  wire logic [CDAT_W-1:0]   i_cfg_data
);

    // saturating load of a delay into the timer
    function automatic logic [TIMER_BITS-1:0] arm(input logic [DLY_W-1:0] d);
        logic [TIMER_BITS-1:0] t;
        if ((d >> TIMER_BITS) != '0) begin
            t = '1;
        end else begin
            t = TIMER_BITS'(d);
        end
        return t;
    endfunction

    // configuration
    logic [DEB_W-1:0] r_cfg_btn_deb, r_cfg_lid_deb;
    logic [DLY_W-1:0] r_cfg_first, r_cfg_gap, r_cfg_wake;
    logic [1:0]       r_cfg_boot;

    // sequencer state
    t_seq_state            r_state, n_state;
    logic [TIMER_BITS-1:0] r_timer, n_timer;
    logic [DEB_W-1:0]      r_bcount, n_bcount, r_lcount, n_lcount;
    logic                  r_bpend, n_bpend, r_lpend, n_lpend;
    logic                  r_prev_btn, n_prev_btn, r_prev_lid, n_prev_lid;
    logic                  r_stable_btn, n_stable_btn, r_stable_lid, n_stable_lid;
    logic                  r_pch, n_pch, r_scan, n_scan, r_started, n_started;
    logic                  ev_wake, ev_button, ev_open, ev_closed;

    // result register
    logic              r_out_valid;
    logic              r_out_pch, r_out_btn, r_out_lid, r_out_bl, r_out_scan;
    logic              r_out_wake, r_out_evb, r_out_evo, r_out_evc;
    logic [CODE_W-1:0] r_out_state;

    logic in_acc, out_acc, cfg_acc;

    assign o_stall     = r_out_valid & i_stall;
    assign in_acc      = i_valid & ~o_stall;
    assign out_acc     = r_out_valid & ~i_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_btn_deb <= RST_BTN_DEBOUNCE;
            r_cfg_lid_deb <= RST_LID_DEBOUNCE;
            r_cfg_first   <= RST_FIRST_PULSE;
            r_cfg_gap     <= RST_RELEASE_GAP;
            r_cfg_wake    <= RST_WAKE_PULSE;
            r_cfg_boot    <= BOOT_NORMAL;
        end else if (cfg_acc) begin
            case (i_cfg_index)
                CFG_BTN_DEBOUNCE: r_cfg_btn_deb <= i_cfg_data[DEB_W-1:0];
                CFG_LID_DEBOUNCE: r_cfg_lid_deb <= i_cfg_data[DEB_W-1:0];
                CFG_FIRST_PULSE:  r_cfg_first   <= i_cfg_data;
                CFG_RELEASE_GAP:  r_cfg_gap     <= i_cfg_data;
                CFG_WAKE_PULSE:   r_cfg_wake    <= i_cfg_data;
                CFG_BOOT_CAUSE:   r_cfg_boot    <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state      = r_state;
        n_timer      = r_timer;
        n_bcount     = r_bcount;
        n_lcount     = r_lcount;
        n_bpend      = r_bpend;
        n_lpend      = r_lpend;
        n_prev_btn   = r_prev_btn;
        n_prev_lid   = r_prev_lid;
        n_stable_btn = r_stable_btn;
        n_stable_lid = r_stable_lid;
        n_pch        = r_pch;
        n_scan       = r_scan;
        n_started    = r_started;
        ev_wake      = 1'b0;
        ev_button    = 1'b0;
        ev_open      = 1'b0;
        ev_closed    = 1'b0;

        if (!r_started) begin
            // first tick: latch levels and apply the boot rule
            n_prev_btn   = i_raw_button;
            n_prev_lid   = i_raw_lid;
            n_stable_btn = i_raw_button;
            n_stable_lid = i_raw_lid;
            n_started    = 1'b1;
            if (r_cfg_boot == BOOT_KBD_RECOVERY
                || (r_cfg_boot == BOOT_KBD_RESET && i_recovery_keys)) begin
                ev_wake = 1'b1;
                n_pch   = 1'b0;
                n_state = ST_RECOVERY;
                n_timer = arm(r_cfg_wake);
            end else if (r_cfg_boot == BOOT_KBD_RESET) begin
                n_pch   = 1'b1;
                n_state = i_raw_button ? ST_EAT : ST_IDLE;
            end else if (r_cfg_boot == BOOT_WAKE_PIN && i_raw_lid) begin
                ev_wake = 1'b1;
                n_pch   = 1'b0;
                n_state = i_raw_button ? ST_WASOFF : ST_LIDOPEN;
                n_timer = arm(r_cfg_wake);
            end else begin
                n_pch   = ~i_raw_button;
                ev_wake = i_raw_button;
            end
        end else begin
            if (r_timer != '0) begin
                n_timer = r_timer - TIMER_BITS'(1);
            end
            if (r_bpend && r_bcount != '0) begin
                n_bcount = r_bcount - DEB_W'(1);
            end
            if (r_lpend && r_lcount != '0) begin
                n_lcount = r_lcount - DEB_W'(1);
            end

            // any raw edge restarts the debounce count
            if (i_raw_button != r_prev_btn) begin
                n_bcount = r_cfg_btn_deb;
                n_bpend  = 1'b1;
                if (i_raw_button) begin
                    n_scan = 1'b0;
                end
            end
            if (i_raw_lid != r_prev_lid) begin
                n_lcount = r_cfg_lid_deb;
                n_lpend  = 1'b1;
            end
            n_prev_btn = i_raw_button;
            n_prev_lid = i_raw_lid;

            // debounced button change, ignored during pulse states
            if (n_bpend && n_bcount == '0) begin
                n_bpend = 1'b0;
                if (i_raw_button != r_stable_btn
                    && r_state != ST_RECOVERY && r_state != ST_LIDOPEN
                    && r_state != ST_WASOFF) begin
                    if (i_raw_button) begin
                        n_stable_btn = 1'b1;
                        n_state      = ST_PRESSED;
                        n_timer      = '0;
                        ev_button    = 1'b1;
                    end else if (r_state == ST_EAT) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_stable_btn = 1'b0;
                        n_state      = ST_RELEASED;
                        n_timer      = '0;
                        n_scan       = 1'b1;
                    end
                end
            end

            // debounced lid change
            if (n_lpend && n_lcount == '0) begin
                n_lpend = 1'b0;
                if (i_raw_lid != r_stable_lid) begin
                    if (i_raw_lid) begin
                        n_stable_lid = 1'b1;
                        ev_open      = 1'b1;
                        if (i_chipset_off) begin
                            ev_wake = 1'b1;
                            n_pch   = 1'b0;
                            n_state = ST_LIDOPEN;
                            n_timer = arm(r_cfg_wake);
                        end
                    end else begin
                        n_stable_lid = 1'b0;
                        ev_closed    = 1'b1;
                    end
                end
            end

            // sequencer step once the delay has run out
            if (n_timer == '0) begin
                case (n_state)
                    ST_PRESSED: begin
                        if (i_chipset_off) begin
                            ev_wake = 1'b1;
                            n_timer = arm(r_cfg_wake);
                            n_state = ST_WASOFF;
                        end else begin
                            n_timer = arm(r_cfg_first);
                            n_state = ST_T0;
                        end
                        n_pch = 1'b0;
                    end
                    ST_T0: begin
                        n_timer = arm(r_cfg_gap);
                        n_state = ST_T1;
                        n_pch   = 1'b1;
                    end
                    ST_T1: begin
                        if (!i_chipset_off) begin
                            n_pch = 1'b0;
                        end
                        n_state = ST_HELD;
                    end
                    ST_RELEASED, ST_LIDOPEN: begin
                        n_pch   = 1'b1;
                        n_state = ST_IDLE;
                    end
                    ST_RECOVERY: begin
                        n_pch   = 1'b1;
                        n_state = i_raw_button ? ST_EAT : ST_IDLE;
                    end
                    ST_WASOFF: begin
                        if (i_raw_button) begin
                            n_state = ST_HELD;
                        end else if (n_stable_btn) begin
                            n_stable_btn = 1'b0;
                            n_state      = ST_RELEASED;
                            n_timer      = '0;
                            n_scan       = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_timer      <= '0;
            r_bcount     <= '0;
            r_lcount     <= '0;
            r_bpend      <= 1'b0;
            r_lpend      <= 1'b0;
            r_prev_btn   <= 1'b0;
            r_prev_lid   <= 1'b0;
            r_stable_btn <= 1'b0;
            r_stable_lid <= 1'b0;
            r_pch        <= 1'b1;
            r_scan       <= 1'b1;
            r_started    <= 1'b0;
        end else if (in_acc) begin
            r_state      <= n_state;
            r_timer      <= n_timer;
            r_bcount     <= n_bcount;
            r_lcount     <= n_lcount;
            r_bpend      <= n_bpend;
            r_lpend      <= n_lpend;
            r_prev_btn   <= n_prev_btn;
            r_prev_lid   <= n_prev_lid;
            r_stable_btn <= n_stable_btn;
            r_stable_lid <= n_stable_lid;
            r_pch        <= n_pch;
            r_scan       <= n_scan;
            r_started    <= n_started;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_pch   <= n_pch;
            r_out_btn   <= n_stable_btn;
            r_out_lid   <= n_stable_lid;
            r_out_bl    <= i_panel_backlight_request & n_stable_lid;
            r_out_scan  <= n_scan;
            r_out_wake  <= ev_wake;
            r_out_evb   <= ev_button;
            r_out_evo   <= ev_open;
            r_out_evc   <= ev_closed;
            r_out_state <= state_code(n_state);
        end
    end

    assign o_valid            = r_out_valid;
    assign o_pch_button_level = r_out_pch;
    assign o_button_debounced = r_out_btn;
    assign o_lid_debounced    = r_out_lid;
    assign o_backlight_on     = r_out_bl;
    assign o_keyboard_scan_on = r_out_scan;
    assign o_wake_chipset     = r_out_wake;
    assign o_event_button     = r_out_evb;
    assign o_event_lid_open   = r_out_evo;
    assign o_event_lid_closed = r_out_evc;
    assign o_sequencer_state  = r_out_state;

endmodule

`default_nettype wire

// ===== rtl/pbls_checker.sv =====
// pbls_checker: port-level assertions for power_button_lid_sequencer_unit
// depends on pbls_pkg; bound to power_button_lid_sequencer_unit at the end of this file
`default_nettype none

module pbls_checker
    import pbls_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              o_stall,
    input wire logic              o_valid,
    input wire logic              i_stall,
    input wire logic              o_pch_button_level,
    input wire logic              o_button_debounced,
    input wire logic              o_lid_debounced,
    input wire logic              o_backlight_on,
    input wire logic              o_event_button,
    input wire logic              o_event_lid_open,
    input wire logic              o_event_lid_closed,
    input wire logic [CODE_W-1:0] o_sequencer_state
);

    // a stalled result request holds its state, pch level and button event
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_sequencer_state)
            && $stable(o_pch_button_level) && $stable(o_event_button)))
        else $error("stalled result changed");

    // lid events agree with the debounced lid flag
    a_lid_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((!o_event_lid_open || o_lid_debounced)
            && (!o_event_lid_closed || !o_lid_debounced)))
        else $error("lid event disagrees with debounced lid");

    // backlight only with the lid open
    a_backlight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_backlight_on) |-> o_lid_debounced)
        else $error("backlight on with lid closed");

    // a button event steps past pressed the same tick; a lid-open wake with no
    // delay on that tick can already be back in idle
    a_btn_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_button) |-> (o_button_debounced
            && (o_sequencer_state == CODE_PRESSED || o_sequencer_state == CODE_T0
                || o_sequencer_state == CODE_WASOFF || o_sequencer_state == CODE_T1
                || o_sequencer_state == CODE_HELD || o_sequencer_state == CODE_LIDOPEN
                || o_sequencer_state == CODE_IDLE)))
        else $error("button event without press");

    // input stall only comes from a full, stalled result register
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without backpressure");

endmodule

bind power_button_lid_sequencer_unit pbls_checker u_pbls_checker (.*);

`default_nettype wire

// ===== tb/pbls_checker.sv =====
// pbls_scoreboard: watches the tick, result and config channels of the button / lid sequencer,
// predicts every result from its own copy of the sequencer and compares in order
// depends on pbls_pkg
`default_nettype none

module pbls_scoreboard
    import pbls_pkg::*;
#(
    parameter int TIMER_BITS = 24
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_tick_valid,
    input  wire logic              i_tick_stall,
    input  wire logic              i_raw_button,
    input  wire logic              i_raw_lid,
    input  wire logic              i_chipset_off,
    input  wire logic              i_recovery_keys,
    input  wire logic              i_backlight_req,
    input  wire logic              i_res_valid,
    input  wire logic              i_res_stall,
    input  wire logic              i_pch_button_level,
    input  wire logic              i_button_debounced,
    input  wire logic              i_lid_debounced,
    input  wire logic              i_backlight_on,
    input  wire logic              i_keyboard_scan_on,
    input  wire logic              i_wake_chipset,
    input  wire logic              i_event_button,
    input  wire logic              i_event_lid_open,
    input  wire logic              i_event_lid_closed,
    input  wire logic [CODE_W-1:0] i_sequencer_state,
    input  wire logic              i_cfg_valid,
    input  wire logic              i_cfg_ready,
    input  wire logic [CIDX_W-1:0] i_cfg_index,
    input  wire logic [CDAT_W-1:0] i_cfg_data,
    output int                     o_errors,
    output int                     o_pending
);

    localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_BITS) - 64'd1);

    typedef struct packed {
        logic button;
        logic lid;
        logic off;
        logic keys;
        logic bl_req;
    } t_tick;

    typedef struct packed {
        logic              pch_level;
        logic              btn_deb;
        logic              lid_deb;
        logic              backlight;
        logic              scan_on;
        logic              wake;
        logic              ev_button;
        logic              ev_open;
        logic              ev_closed;
        logic [CODE_W-1:0] seq;
    } t_status;

    // register copies
    logic [DEB_W-1:0]  btn_deb_ticks;
    logic [DEB_W-1:0]  lid_deb_ticks;
    logic [DLY_W-1:0]  first_ticks;
    logic [DLY_W-1:0]  gap_ticks;
    logic [DLY_W-1:0]  wake_ticks;
    logic [1:0]        boot_cause;

    // sequencer copy
    logic [CODE_W-1:0] seq_code;
    logic [31:0]       seq_timer;
    logic [DEB_W-1:0]  btn_count;
    logic [DEB_W-1:0]  lid_count;
    logic              btn_pending;
    logic              lid_pending;
    logic              prev_button;
    logic              prev_lid;
    logic              deb_button;
    logic              deb_lid;
    logic              pch_level;
    logic              scan_on;
    logic              booted;

    t_status status_due[$];
    int      results_seen;

    function automatic void arm(input logic [DLY_W-1:0] ticks);
        seq_timer = (32'(ticks) > TIMER_MAX) ? TIMER_MAX : 32'(ticks);
    endfunction

    function automatic void drop_button();
        if (deb_button) begin
            deb_button = 1'b0;
            seq_code   = CODE_RELEASED;
            seq_timer  = '0;
            scan_on    = 1'b1;
        end
    endfunction

    function automatic t_status next_status(input t_tick t);
        t_status r;
        logic    wake;
        logic    ev_btn;
        logic    ev_open;
        logic    ev_closed;
        wake      = 1'b0;
        ev_btn    = 1'b0;
        ev_open   = 1'b0;
        ev_closed = 1'b0;
        if (!booted) begin
            prev_button = t.button;
            prev_lid    = t.lid;
            deb_button  = t.button;
            deb_lid     = t.lid;
            booted      = 1'b1;
            if (boot_cause == BOOT_KBD_RECOVERY || (boot_cause == BOOT_KBD_RESET && t.keys)) begin
                wake      = 1'b1;
                pch_level = 1'b0;
                seq_code  = CODE_RECOVERY;
                arm(wake_ticks);
            end else if (boot_cause == BOOT_KBD_RESET) begin
                pch_level = 1'b1;
                seq_code  = t.button ? CODE_EAT : CODE_IDLE;
            end else if (boot_cause == BOOT_WAKE_PIN && t.lid) begin
                wake      = 1'b1;
                pch_level = 1'b0;
                seq_code  = t.button ? CODE_WASOFF : CODE_LIDOPEN;
                arm(wake_ticks);
            end else begin
                pch_level = ~t.button;
                wake      = t.button;
            end
        end else begin
            if (seq_timer != 0) seq_timer = seq_timer - 1;
            if (btn_pending && btn_count != 0) btn_count = btn_count - 1'b1;
            if (lid_pending && lid_count != 0) lid_count = lid_count - 1'b1;

            // any raw edge restarts that debounce count
            if (t.button != prev_button) begin
                btn_count   = btn_deb_ticks;
                btn_pending = 1'b1;
                if (t.button) scan_on = 1'b0;
            end
            if (t.lid != prev_lid) begin
                lid_count   = lid_deb_ticks;
                lid_pending = 1'b1;
            end
            prev_button = t.button;
            prev_lid    = t.lid;

            if (btn_pending && btn_count == 0) begin
                btn_pending = 1'b0;
                // pulse states ignore the button
                if (t.button != deb_button && seq_code != CODE_RECOVERY &&
                    seq_code != CODE_LIDOPEN && seq_code != CODE_WASOFF) begin
                    if (t.button) begin
                        deb_button = 1'b1;
                        seq_code   = CODE_PRESSED;
                        seq_timer  = '0;
                        ev_btn     = 1'b1;
                    end else if (seq_code == CODE_EAT) begin
                        seq_code = CODE_IDLE;
                    end else begin
                        drop_button();
                    end
                end
            end

            if (lid_pending && lid_count == 0) begin
                lid_pending = 1'b0;
                if (t.lid != deb_lid) begin
                    deb_lid = t.lid;
                    if (t.lid) begin
                        ev_open = 1'b1;
                        if (t.off) begin
                            wake      = 1'b1;
                            pch_level = 1'b0;
                            seq_code  = CODE_LIDOPEN;
                            arm(wake_ticks);
                        end
                    end else begin
                        ev_closed = 1'b1;
                    end
                end
            end

            if (seq_timer == 0) begin
                case (seq_code)
                    CODE_PRESSED: begin
                        if (t.off) begin
                            wake     = 1'b1;
                            seq_code = CODE_WASOFF;
                            arm(wake_ticks);
                        end else begin
                            seq_code = CODE_T0;
                            arm(first_ticks);
                        end
                        pch_level = 1'b0;
                    end
                    CODE_T0: begin
                        seq_code  = CODE_T1;
                        pch_level = 1'b1;
                        arm(gap_ticks);
                    end
                    CODE_T1: begin
                        if (!t.off) pch_level = 1'b0;
                        seq_code = CODE_HELD;
                    end
                    CODE_RELEASED, CODE_LIDOPEN: begin
                        pch_level = 1'b1;
                        seq_code  = CODE_IDLE;
                    end
                    CODE_RECOVERY: begin
                        pch_level = 1'b1;
                        seq_code  = t.button ? CODE_EAT : CODE_IDLE;
                    end
                    CODE_WASOFF: begin
                        if (t.button) seq_code = CODE_HELD;
                        else drop_button();
                    end
                    default: ;
                endcase
            end
        end
        r.pch_level = pch_level;
        r.btn_deb   = deb_button;
        r.lid_deb   = deb_lid;
        r.backlight = t.bl_req & deb_lid;
        r.scan_on   = scan_on;
        r.wake      = wake;
        r.ev_button = ev_btn;
        r.ev_open   = ev_open;
        r.ev_closed = ev_closed;
        r.seq       = seq_code;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_status got;
        t_status want;
        if (!i_rst_n) begin
            btn_deb_ticks = RST_BTN_DEBOUNCE;
            lid_deb_ticks = RST_LID_DEBOUNCE;
            first_ticks   = RST_FIRST_PULSE;
            gap_ticks     = RST_RELEASE_GAP;
            wake_ticks    = RST_WAKE_PULSE;
            boot_cause    = BOOT_NORMAL;
            seq_code      = CODE_IDLE;
            seq_timer     = '0;
            btn_count     = '0;
            lid_count     = '0;
            btn_pending   = 1'b0;
            lid_pending   = 1'b0;
            prev_button   = 1'b0;
            prev_lid      = 1'b0;
            deb_button    = 1'b0;
            deb_lid       = 1'b0;
            pch_level     = 1'b1;
            scan_on       = 1'b1;
            booted        = 1'b0;
            status_due.delete();
            o_errors      = 0;
            results_seen  = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BTN_DEBOUNCE: btn_deb_ticks = i_cfg_data[DEB_W-1:0];
                    CFG_LID_DEBOUNCE: lid_deb_ticks = i_cfg_data[DEB_W-1:0];
                    CFG_FIRST_PULSE:  first_ticks   = i_cfg_data[DLY_W-1:0];
                    CFG_RELEASE_GAP:  gap_ticks     = i_cfg_data[DLY_W-1:0];
                    CFG_WAKE_PULSE:   wake_ticks    = i_cfg_data[DLY_W-1:0];
                    CFG_BOOT_CAUSE:   boot_cause    = i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_tick_valid && !i_tick_stall) begin
                status_due.push_back(next_status({i_raw_button, i_raw_lid, i_chipset_off,
                                                  i_recovery_keys, i_backlight_req}));
            end
            if (i_res_valid && !i_res_stall) begin
                got = {i_pch_button_level, i_button_debounced, i_lid_debounced, i_backlight_on,
                       i_keyboard_scan_on, i_wake_chipset, i_event_button, i_event_lid_open,
                       i_event_lid_closed, i_sequencer_state};
                if (status_due.size() == 0) begin
                    if (o_errors < 10)
                        $display("scoreboard: result %0d arrived with nothing pending",
                                 results_seen);
                    o_errors++;
                end else begin
                    want = status_due.pop_front();
                    if (got !== want) begin
                        if (o_errors < 10) begin
                            $display("scoreboard: result %0d expected pch=%b btn=%b lid=%b bl=%b",
                                     results_seen, want.pch_level, want.btn_deb, want.lid_deb,
                                     want.backlight, " scan=%b wake=%b ev=%b%b%b st=%0d",
                                     want.scan_on, want.wake, want.ev_button, want.ev_open,
                                     want.ev_closed, want.seq);
                            $display("scoreboard: result %0d actual   pch=%b btn=%b lid=%b bl=%b",
                                     results_seen, got.pch_level, got.btn_deb, got.lid_deb,
                                     got.backlight, " scan=%b wake=%b ev=%b%b%b st=%0d",
                                     got.scan_on, got.wake, got.ev_button, got.ev_open,
                                     got.ev_closed, got.seq);
                        end
                        o_errors++;
                    end
                end
                results_seen++;
            end
        end
        o_pending = status_due.size();
    end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// tb_top: clock, reset, tick stimulus, config phases and verdict for the button / lid sequencer
// depends on pbls_pkg, power_button_lid_sequencer_unit and pbls_scoreboard
`default_nettype none

module tb_top
    import pbls_pkg::*;
();

    localparam int TIMER_BITS = 24;

    // indexes past the last register, ignored by the block
    localparam logic [CIDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CIDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [CDAT_W-1:0] CFG_ALL_ONES = '1;

    typedef struct packed {
        logic button;
        logic lid;
        logic off;
        logic keys;
        logic bl_req;
    } t_tick;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_raw_button = 1'b0;
    logic              i_raw_lid = 1'b0;
    logic              i_chipset_off = 1'b0;
    logic              i_recovery_keys = 1'b0;
    logic              i_panel_backlight_request = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic              o_pch_button_level;
    logic              o_button_debounced;
    logic              o_lid_debounced;
    logic              o_backlight_on;
    logic              o_keyboard_scan_on;
    logic              o_wake_chipset;
    logic              o_event_button;
    logic              o_event_lid_open;
    logic              o_event_lid_closed;
    logic [CODE_W-1:0] o_sequencer_state;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CIDX_W-1:0] i_cfg_index = '0;
    logic [CDAT_W-1:0] i_cfg_data = '0;

    int    mismatches;
    int    pending;
    bit    gaps_on = 1'b1;
    int    holds_asked = 0;
    t_tick hold_levels;

    power_button_lid_sequencer_unit #(.TIMER_BITS(TIMER_BITS)) dut (.*);

    pbls_scoreboard #(.TIMER_BITS(TIMER_BITS)) u_scoreboard (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_tick_valid       (i_valid),
        .i_tick_stall       (o_stall),
        .i_raw_button       (i_raw_button),
        .i_raw_lid          (i_raw_lid),
        .i_chipset_off      (i_chipset_off),
        .i_recovery_keys    (i_recovery_keys),
        .i_backlight_req    (i_panel_backlight_request),
        .i_res_valid        (o_valid),
        .i_res_stall        (i_stall),
        .i_pch_button_level (o_pch_button_level),
        .i_button_debounced (o_button_debounced),
        .i_lid_debounced    (o_lid_debounced),
        .i_backlight_on     (o_backlight_on),
        .i_keyboard_scan_on (o_keyboard_scan_on),
        .i_wake_chipset     (o_wake_chipset),
        .i_event_button     (o_event_button),
        .i_event_lid_open   (o_event_lid_open),
        .i_event_lid_closed (o_event_lid_closed),
        .i_sequencer_state  (o_sequencer_state),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_errors           (mismatches),
        .o_pending          (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("tb_top: errors");
        $finish;
    end

    // result side: short random stalls, plus one long hold when asked
    initial begin : receiver
        int stall_left;
        int holds_done;
        stall_left = 0;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (holds_done != holds_asked) begin
                holds_done = holds_asked;
                stall_left = 80;
            end else if (stall_left == 0 && gaps_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 5);
            end
            i_stall <= (stall_left != 0);
            if (stall_left != 0) stall_left--;
        end
    end

    function automatic t_tick levels(input logic b, l, o, k, r);
        return {b, l, o, k, r};
    endfunction

    task automatic offer(input t_tick t);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid                   <= 1'b1;
        i_raw_button              <= t.button;
        i_raw_lid                 <= t.lid;
        i_chipset_off             <= t.off;
        i_recovery_keys           <= t.keys;
        i_panel_backlight_request <= t.bl_req;
        do @(posedge i_clk); while (o_stall);
    endtask

    // stop offering and let every pending result come out
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        @(posedge i_clk);
    endtask

    // leaves the config valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic load_settings(input logic [CDAT_W-1:0] btn_deb, lid_deb, first, gap, wake,
                                 input logic [1:0] boot, input bit poke_spare);
        write_reg(CFG_BTN_DEBOUNCE, btn_deb);
        write_reg(CFG_LID_DEBOUNCE, lid_deb);
        write_reg(CFG_FIRST_PULSE, first);
        write_reg(CFG_RELEASE_GAP, gap);
        write_reg(CFG_WAKE_PULSE, wake);
        write_reg(CFG_BOOT_CAUSE, {22'($urandom), boot});
        if (poke_spare) begin
            write_reg(CFG_SPARE_LO, 24'($urandom));
            write_reg(CFG_SPARE_HI, 24'($urandom));
        end
        i_cfg_valid <= 1'b0;
    endtask

    // level changes held long enough to walk the sequencer, with some contact bounce
    task automatic exercise(input int n_items, input int span);
        int    sent;
        int    hold;
        int    bounces;
        int    k;
        t_tick noisy;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: hold_levels.button = ~hold_levels.button;
                5, 6:          hold_levels.lid    = ~hold_levels.lid;
                7:             hold_levels.off    = ~hold_levels.off;
                8:             hold_levels.bl_req = ~hold_levels.bl_req;
                default:       hold_levels.keys   = ~hold_levels.keys;
            endcase
            if ($urandom_range(0, 4) == 0) begin
                bounces = $urandom_range(1, 3);
                noisy   = hold_levels;
                for (k = 0; k < bounces; k++) begin
                    noisy.button = 1'($urandom_range(0, 1));
                    noisy.lid    = 1'($urandom_range(0, 1));
                    offer(noisy);
                    sent++;
                end
            end
            hold = $urandom_range(1, span);
            for (k = 0; k < hold; k++) begin
                offer(hold_levels);
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        logic [CDAT_W-1:0] d_btn;
        logic [CDAT_W-1:0] d_lid;
        logic [CDAT_W-1:0] d_first;
        logic [CDAT_W-1:0] d_gap;
        logic [CDAT_W-1:0] d_wake;
        int                span;
        int                ph;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // short delays; upper data bits on the debounce writes must be dropped
        load_settings(24'hF00001, 24'hA00001, 24'd1, 24'd2, 24'd1,
                      2'($urandom_range(0, 3)), 1'b1);

        // first tick takes the boot rule
        hold_levels = t_tick'(5'($urandom));
        offer(hold_levels);
        repeat (2) offer(levels(0, 0, 0, 0, 0));
        repeat (6) offer(levels(1, 0, 0, 0, 1));    // press, running chipset: t0, t1, held
        repeat (3) offer(levels(0, 0, 0, 0, 1));    // release
        repeat (3) offer(levels(0, 1, 1, 0, 1));    // lid opens on an off chipset
        repeat (2) offer(levels(0, 0, 0, 1, 0));    // lid closes
        repeat (4) offer(levels(1, 0, 1, 1, 0));    // press on an off chipset, stretched wake
        offer(levels(0, 0, 1, 0, 0));
        offer(levels(1, 0, 1, 0, 0));
        repeat (2) offer(levels(0, 0, 0, 0, 0));
        hold_levels = levels(0, 0, 0, 0, 0);
        drain();

        // zero debounce and zero delays
        load_settings('0, '0, '0, '0, '0, BOOT_NORMAL, 1'b0);
        exercise(40, 4);

        for (ph = 0; ph < 6; ph++) begin
            drain();
            gaps_on = (ph != 3);
            d_btn   = 24'($urandom_range(0, 6));
            d_lid   = 24'($urandom_range(0, 6));
            d_first = 24'($urandom_range(0, 5));
            d_gap   = 24'($urandom_range(0, 8));
            d_wake  = 24'($urandom_range(0, 5));
            load_settings(d_btn, d_lid, d_first, d_gap, d_wake,
                          2'($urandom_range(0, 3)), ph == 5);
            span = int'(d_btn) + int'(d_lid) + int'(d_first) + int'(d_gap) + int'(d_wake) + 3;
            if (span > 24) span = 24;
            // long receiver hold while ticks keep coming
            if (ph == 2) holds_asked++;
            exercise(22, span);
            if (ph == 1) drain();
            exercise(22, span);
        end

        // largest settings, no idling to the end
        drain();
        gaps_on = 1'b0;
        load_settings(CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES,
                      BOOT_WAKE_PIN, 1'b0);
        exercise(40, 12);
        drain();
        repeat (4) @(posedge i_clk);

        if (mismatches == 0 && pending == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== power_button_lid_sequencer_unit.f =====
rtl/pbls_pkg.sv
rtl/power_button_lid_sequencer_unit.sv
rtl/pbls_checker.sv
tb/pbls_checker.sv
tb/tb_top.sv
